FILE: hdl/xs256_pkg.sv
// Shared constants and types of the xoshiro256** generator.
`timescale 1ns / 1ps

package xs256_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned HalfWidth = WordWidth / 2;
  localparam int unsigned OpWidth   = 2;
  localparam int unsigned NumWords  = 4;
  localparam int unsigned FracShift = 11;

  // splitmix64 seeding constants.
  localparam logic [WordWidth-1:0] SmGamma = 64'h9E3779B97F4A7C15;
  localparam logic [WordWidth-1:0] SmMul1  = 64'hBF58476D1CE4E5B9;
  localparam logic [WordWidth-1:0] SmMul2  = 64'h94D049BB133111EB;

  typedef enum logic [OpWidth-1:0] {
    OP_RAW      = 2'd0,
    OP_BOUNDED  = 2'd1,
    OP_FRACTION = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

endpackage

FILE: hdl/xs256_if.sv
// Request and response channel interfaces of the xoshiro256** generator.
`timescale 1ns / 1ps

interface xs256_req_if import xs256_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OpWidth-1:0]   op;
  logic [WordWidth-1:0] bound;

  modport source (output valid, output op, output bound, input ready);
  modport sink   (input valid, input op, input bound, output ready);
endinterface

interface xs256_rsp_if import xs256_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: hdl/xoshiro256_star_star_generator_core.sv
// A raw or fraction request runs through S_DRAW1, S_DRAW2 and S_DONE, where its beat is
// registered; a new one is taken back in S_IDLE. A bounded request sends its first draw and
// each redraw through the shared 32x32 multiplier (four partial products) and, once, through
// the bit-serial remainder unit when the first product falls in the rejection zone. Zero bound
// and the unused op skip to S_DONE. Reset and every seed write run the splitmix64 expansion
// with the request side not ready. After reset the state is the expansion of seed 0.
`timescale 1ns / 1ps

module xoshiro256_star_star_generator_core import xs256_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [WordWidth-1:0] cfg_wdata_i,
  xs256_req_if.sink            req_i,
  xs256_rsp_if.source          rsp_o
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_SEED_ADD   = 10'b0000000010,
    S_SEED_MIX   = 10'b0000000100,
    S_SEED_STORE = 10'b0000001000,
    S_MUL        = 10'b0000010000,
    S_DRAW1      = 10'b0000100000,
    S_DRAW2      = 10'b0001000000,
    S_BCHK       = 10'b0010000000,
    S_DIV        = 10'b0100000000,
    S_DONE       = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    MPH_MIX1  = 2'd0,
    MPH_MIX2  = 2'd1,
    MPH_BOUND = 2'd2
  } mphase_e;

  function automatic logic [WordWidth-1:0] rotl(logic [WordWidth-1:0] v, int unsigned n);
    return (v << n) | (v >> (WordWidth - n));
  endfunction

  state_e                   state_q, state_d;
  mphase_e                  mph_q, mph_d;
  logic [WordWidth-1:0]     ctr_q, ctr_d;
  logic [1:0]               seed_idx_q, seed_idx_d;
  logic [WordWidth-1:0]     gen_q [NumWords];
  logic [WordWidth-1:0]     gen_d [NumWords];
  logic [WordWidth-1:0]     mopa_q, mopa_d, mopb_q, mopb_d;
  logic [2:0]               mul_cnt_q, mul_cnt_d;
  logic [WordWidth-1:0]     prod_q, prod_d;
  logic [2*WordWidth-1:0]   acc_q, acc_d;
  logic [WordWidth-1:0]     t_q, t_d;
  op_e                      op_q, op_d;
  logic [WordWidth-1:0]     bound_q, bound_d;
  logic                     thr_valid_q, thr_valid_d;
  logic [WordWidth-1:0]     rem_q, rem_d, num_q, num_d;
  logic [5:0]               div_cnt_q, div_cnt_d;
  logic [WordWidth-1:0]     res_q, res_d;
  logic                     rsp_valid_q, rsp_valid_d;
  logic [WordWidth-1:0]     rsp_value_q, rsp_value_d;

  logic [HalfWidth-1:0]     mul_a, mul_b;
  logic [2*WordWidth-1:0]   acc_add;
  logic [WordWidth-1:0]     seed_z, draw_r, draw_res, acc_lo, acc_hi;
  logic [WordWidth:0]       div_sh, div_diff;
  logic [WordWidth-1:0]     g2a, g3a;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.value = rsp_value_q;

  // Shared multiplier: one 32x32 partial product per cycle.
  assign mul_a  = mul_cnt_q[1] ? mopa_q[WordWidth-1:HalfWidth] : mopa_q[HalfWidth-1:0];
  assign mul_b  = mul_cnt_q[0] ? mopb_q[WordWidth-1:HalfWidth] : mopb_q[HalfWidth-1:0];
  assign prod_d = {{HalfWidth{1'b0}}, mul_a} * {{HalfWidth{1'b0}}, mul_b};

  // The product registered last cycle belongs to the partial product before the current one.
  always_comb begin
    case (mul_cnt_q) inside
      3'd1:    acc_add = {{WordWidth{1'b0}}, prod_q};
      3'd2,
      3'd3:    acc_add = {{HalfWidth{1'b0}}, prod_q, {HalfWidth{1'b0}}};
      3'd4:    acc_add = {prod_q, {WordWidth{1'b0}}};
      default: acc_add = '0;
    endcase
  end

  assign acc_lo   = acc_q[WordWidth-1:0];
  assign acc_hi   = acc_q[2*WordWidth-1:WordWidth];
  assign seed_z   = ctr_q + SmGamma;
  assign draw_r   = rotl(t_q, 7);
  assign draw_res = draw_r + (draw_r << 3);
  assign div_sh   = {rem_q, num_q[WordWidth-1]};
  assign div_diff = div_sh - {1'b0, bound_q};
  assign g2a      = gen_q[2] ^ gen_q[0];
  assign g3a      = gen_q[3] ^ gen_q[1];

  always_comb begin
    state_d     = state_q;
    mph_d       = mph_q;
    ctr_d       = ctr_q;
    seed_idx_d  = seed_idx_q;
    gen_d       = gen_q;
    mopa_d      = mopa_q;
    mopb_d      = mopb_q;
    mul_cnt_d   = mul_cnt_q;
    acc_d       = acc_q;
    t_d         = t_q;
    op_d        = op_q;
    bound_d     = bound_q;
    thr_valid_d = thr_valid_q;
    rem_d       = rem_q;
    num_d       = num_q;
    div_cnt_d   = div_cnt_q;
    res_d       = res_q;
    rsp_valid_d = rsp_valid_q & ~rsp_o.ready;
    rsp_value_d = rsp_value_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d        = op_e'(req_i.op);
          bound_d     = req_i.bound;
          thr_valid_d = 1'b0;
          res_d       = '0;
          if (req_i.op == OP_RAW || req_i.op == OP_FRACTION ||
              (req_i.op == OP_BOUNDED && req_i.bound != '0)) begin
            state_d = S_DRAW1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SEED_ADD: begin
        ctr_d     = seed_z;
        mopa_d    = seed_z ^ (seed_z >> 30);
        mopb_d    = SmMul1;
        mph_d     = MPH_MIX1;
        mul_cnt_d = '0;
        state_d   = S_MUL;
      end
      S_SEED_MIX: begin
        mopa_d    = acc_lo ^ (acc_lo >> 27);
        mopb_d    = SmMul2;
        mph_d     = MPH_MIX2;
        mul_cnt_d = '0;
        state_d   = S_MUL;
      end
      S_SEED_STORE: begin
        gen_d[seed_idx_q] = acc_lo ^ (acc_lo >> 31);
        seed_idx_d        = seed_idx_q + 2'd1;
        state_d           = (seed_idx_q == 2'd3) ? S_IDLE : S_SEED_ADD;
      end
      S_MUL: begin
        acc_d     = (mul_cnt_q == 3'd0) ? '0 : acc_q + acc_add;
        mul_cnt_d = mul_cnt_q + 3'd1;
        if (mul_cnt_q == 3'd4) begin
          case (mph_q)
            MPH_MIX1: state_d = S_SEED_MIX;
            MPH_MIX2: state_d = S_SEED_STORE;
            default:  state_d = S_BCHK;
          endcase
        end
      end
      S_DRAW1: begin
        t_d      = gen_q[1] + (gen_q[1] << 2);
        gen_d[0] = gen_q[0] ^ g3a;
        gen_d[1] = gen_q[1] ^ g2a;
        gen_d[2] = g2a ^ (gen_q[1] << 17);
        gen_d[3] = rotl(g3a, 45);
        state_d  = S_DRAW2;
      end
      S_DRAW2: begin
        unique case (op_q)
          OP_BOUNDED: begin
            mopa_d    = draw_res;
            mopb_d    = bound_q;
            mph_d     = MPH_BOUND;
            mul_cnt_d = '0;
            state_d   = S_MUL;
          end
          OP_FRACTION: begin
            res_d   = draw_res >> FracShift;
            state_d = S_DONE;
          end
          default: begin
            res_d   = draw_res;
            state_d = S_DONE;
          end
        endcase
      end
      S_BCHK: begin
        if (thr_valid_q) begin
          if (acc_lo < rem_q) begin
            state_d = S_DRAW1;
          end else begin
            res_d   = acc_hi;
            state_d = S_DONE;
          end
        end else if (acc_lo < bound_q) begin
          // Rejection zone reached: work out 2^64 mod bound once for this beat.
          num_d     = '0 - bound_q;
          rem_d     = '0;
          div_cnt_d = 6'd63;
          state_d   = S_DIV;
        end else begin
          res_d   = acc_hi;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        rem_d     = div_diff[WordWidth] ? div_sh[WordWidth-1:0] : div_diff[WordWidth-1:0];
        num_d     = num_q << 1;
        div_cnt_d = div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd0) begin
          thr_valid_d = 1'b1;
          state_d     = S_BCHK;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_value_d = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A seed write restarts the expansion from the new value.
    if (cfg_we_i) begin
      ctr_d      = cfg_wdata_i;
      seed_idx_d = '0;
      state_d    = S_SEED_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SEED_ADD;
      ctr_q       <= '0;
      seed_idx_q  <= '0;
      rsp_valid_q <= 1'b0;
      mul_cnt_q   <= '0;
      mph_q       <= MPH_MIX1;
      thr_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      seed_idx_q  <= seed_idx_d;
      rsp_valid_q <= rsp_valid_d;
      mul_cnt_q   <= mul_cnt_d;
      mph_q       <= mph_d;
      thr_valid_q <= thr_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q       <= gen_d;
    mopa_q      <= mopa_d;
    mopb_q      <= mopb_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    t_q         <= t_d;
    op_q        <= op_d;
    bound_q     <= bound_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    res_q       <= res_d;
    rsp_value_q <= rsp_value_d;
  end

  a_cfg_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_i.ready)
    else $error("request side ready right after a seed write");

  a_div_rem_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_cnt_q == 6'd0) |=> (rem_q < bound_q))
    else $error("rejection threshold not below the bound");

  a_div_nonzero_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (bound_q != '0))
    else $error("remainder unit running with a zero bound");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("response beat raised outside the finishing step");

endmodule
